// File: rtl/core/blga_pkg.sv
`timescale 1ns / 1ps
package blga_pkg;

    localparam int LEVEL_W     = 6;
    localparam int LUX_W       = 16;
    localparam int OUT_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OUT_W-1:0] OUT_MAX         = 12'd4095;
    localparam logic [OUT_W-1:0] DRIVE_FLOOR_RST = 12'd40;
    localparam logic [LUX_W-1:0] LUX_FACTOR_RST  = 16'd100;

    localparam int LEVEL_CAP   = 40;
    localparam int LUX_SAT_W   = 10;
    localparam int LUX_CAP     = 1000;
    localparam int RATIO_FRAC  = 8;
    localparam int RATIO_W     = LUX_SAT_W + RATIO_FRAC;

    localparam int GAIN_W      = 16;
    localparam int EXP_W       = 5;
    localparam int LOG_FRAC_W  = 16;
    localparam int MANT_W      = 31;
    localparam int AMB_W       = 24;

    localparam int DIVN_W      = EXP_W + LOG_FRAC_W + 2;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP5 = 24'hCCCCCD;
    localparam int RECIP_SHIFT = 26;
    localparam int MU_W        = 20;
    localparam int LOG_BIAS    = 1 << 19;
    localparam int EXP_SHIFT_BIAS = 22;
    localparam int SHIFT_W     = 5;

    localparam int PROD_W      = GAIN_W + AMB_W + OUT_W;
    localparam int SCALE_SHIFT = 29;
    localparam int SUM_W       = PROD_W - SCALE_SHIFT + 1;

    localparam int DIV_STEPS   = RATIO_W;
    localparam int LOG_STEPS   = LOG_FRAC_W;
    localparam int EXP_STEPS   = LOG_FRAC_W;
    localparam int PIPE_LATENCY = 1 + DIV_STEPS + (2 + LOG_STEPS) + (2 + EXP_STEPS) + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_FLOOR = 2'd0,
        CFG_LUX_FACTOR  = 2'd1,
        CFG_INVERT      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [GAIN_W-1:0] gain;
    } t_tag;

    localparam logic [GAIN_W-1:0] LEVEL_GAMMA [0:LEVEL_CAP] = '{
        16'd0,     16'd11,    16'd52,    16'd126,   16'd237,
        16'd388,   16'd580,   16'd813,   16'd1091,  16'd1414,
        16'd1783,  16'd2199,  16'd2663,  16'd3175,  16'd3738,
        16'd4350,  16'd5014,  16'd5729,  16'd6497,  16'd7318,
        16'd8192,  16'd9120,  16'd10103, 16'd11141, 16'd12235,
        16'd13384, 16'd14590, 16'd15853, 16'd17174, 16'd18552,
        16'd19989, 16'd21484, 16'd23038, 16'd24652, 16'd26326,
        16'd28059, 16'd29853, 16'd31708, 16'd33624, 16'd35601,
        16'd37641
    };

    function automatic logic [63:0] f_isqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (b != '0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q1.30 factor 2^(2^-k)
    function automatic logic [MANT_W-1:0] f_exp2_coef(input int k);
        logic [63:0] c;
        int          j;
        c = f_isqrt(64'd2 << 60);
        for (j = 1; j < 16; j++) begin
            if (j < k) begin
                c = f_isqrt(c << 30);
            end
        end
        return c[MANT_W-1:0];
    endfunction

endpackage

// File: rtl/core/blga_divider.sv
`timescale 1ns / 1ps
module blga_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  blga_pkg::t_tag                 i_tag,
    input  logic [blga_pkg::RATIO_W-1:0]   i_num,
    input  logic [blga_pkg::LUX_W-1:0]     i_den,
    output blga_pkg::t_tag                 o_tag,
    output logic [blga_pkg::RATIO_W-1:0]   o_quot
);
    import blga_pkg::*;

    t_tag               r_tag  [0:DIV_STEPS-1];
    logic [RATIO_W-1:0] r_work [0:DIV_STEPS-1];
    logic [LUX_W-1:0]   r_rem  [0:DIV_STEPS-1];

    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_step
        t_tag               w_tag_in;
        logic [RATIO_W-1:0] w_work_in;
        logic [LUX_W-1:0]   w_rem_in;
        logic [LUX_W:0]     w_trial;
        logic               w_ge;

        if (gi == 0) begin : g_first
            assign w_tag_in  = i_tag;
            assign w_work_in = i_num;
            assign w_rem_in  = '0;
        end else begin : g_next
            assign w_tag_in  = r_tag[gi-1];
            assign w_work_in = r_work[gi-1];
            assign w_rem_in  = r_rem[gi-1];
        end

        assign w_trial = {w_rem_in, w_work_in[RATIO_W-1]};
        assign w_ge    = (w_trial >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[gi] <= '0;
            end else begin
                r_tag[gi] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_work[gi] <= {w_work_in[RATIO_W-2:0], w_ge};
            r_rem[gi]  <= w_ge ? LUX_W'(w_trial - {1'b0, i_den}) : w_trial[LUX_W-1:0];
        end
    end

    assign o_tag  = r_tag[DIV_STEPS-1];
    assign o_quot = r_work[DIV_STEPS-1];

endmodule

// File: rtl/core/blga_log2.sv
`timescale 1ns / 1ps
module blga_log2 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  blga_pkg::t_tag                   i_tag,
    input  logic [blga_pkg::RATIO_W-1:0]     i_ratio,
    output blga_pkg::t_tag                   o_tag,
    output logic [blga_pkg::EXP_W-1:0]       o_int,
    output logic [blga_pkg::LOG_FRAC_W-1:0]  o_frac
);
    import blga_pkg::*;

    logic [EXP_W-1:0]      w_lead;
    t_tag                  r_a_tag;
    logic [EXP_W-1:0]      r_a_int;
    logic [RATIO_W-1:0]    r_a_ratio;
    t_tag                  r_b_tag;
    logic [EXP_W-1:0]      r_b_int;
    logic [MANT_W-1:0]     r_b_mant;

    t_tag                  r_tag  [0:LOG_STEPS-1];
    logic [EXP_W-1:0]      r_int  [0:LOG_STEPS-1];
    logic [MANT_W-1:0]     r_mant [0:LOG_STEPS-1];
    logic [LOG_FRAC_W-1:0] r_frac [0:LOG_STEPS-1];

    always_comb begin
        w_lead = '0;
        for (int i = 0; i < RATIO_W; i++) begin
            if (i_ratio[i]) begin
                w_lead = EXP_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
        end else begin
            r_a_tag <= '{valid: i_tag.valid,
                         zero:  i_tag.zero | (i_ratio == '0),
                         gain:  i_tag.gain};
            r_b_tag <= r_a_tag;
        end
    end

    // normalize to Q1.30
    always_ff @(posedge i_clk) begin
        r_a_int   <= w_lead;
        r_a_ratio <= i_ratio;
        r_b_int   <= r_a_int;
        r_b_mant  <= MANT_W'(r_a_ratio) << (EXP_W'(MANT_W - 1) - r_a_int);
    end

    for (genvar gi = 0; gi < LOG_STEPS; gi++) begin : g_step
        t_tag                  w_tag_in;
        logic [EXP_W-1:0]      w_int_in;
        logic [MANT_W-1:0]     w_mant_in;
        logic [LOG_FRAC_W-1:0] w_frac_in;
        logic [2*MANT_W-1:0]   w_sq;
        logic [MANT_W:0]       w_scaled;

        if (gi == 0) begin : g_first
            assign w_tag_in  = r_b_tag;
            assign w_int_in  = r_b_int;
            assign w_mant_in = r_b_mant;
            assign w_frac_in = '0;
        end else begin : g_next
            assign w_tag_in  = r_tag[gi-1];
            assign w_int_in  = r_int[gi-1];
            assign w_mant_in = r_mant[gi-1];
            assign w_frac_in = r_frac[gi-1];
        end

        assign w_sq     = (2*MANT_W)'(w_mant_in) * (2*MANT_W)'(w_mant_in);
        assign w_scaled = w_sq[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[gi] <= '0;
            end else begin
                r_tag[gi] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_int[gi]  <= w_int_in;
            r_mant[gi] <= w_scaled[MANT_W] ? w_scaled[MANT_W:1] : w_scaled[MANT_W-1:0];
            r_frac[gi] <= {w_frac_in[LOG_FRAC_W-2:0], w_scaled[MANT_W]};
        end
    end

    assign o_tag  = r_tag[LOG_STEPS-1];
    assign o_int  = r_int[LOG_STEPS-1];
    assign o_frac = r_frac[LOG_STEPS-1];

endmodule

// File: rtl/core/blga_exp2.sv
`timescale 1ns / 1ps
module blga_exp2 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  blga_pkg::t_tag                   i_tag,
    input  logic [blga_pkg::EXP_W-1:0]       i_int,
    input  logic [blga_pkg::LOG_FRAC_W-1:0]  i_frac,
    output blga_pkg::t_tag                   o_tag,
    output logic [blga_pkg::AMB_W-1:0]       o_ambient
);
    import blga_pkg::*;

    localparam int MUL_W = DIVN_W + RECIP_W;

    logic [DIVN_W-1:0]  w_num;
    logic [MUL_W-1:0]   w_mul;
    t_tag               r_a_tag;
    logic [MU_W-1:0]    r_a_mu;

    t_tag               r_tag [0:EXP_STEPS-1];
    logic [MU_W-1:0]    r_mu  [0:EXP_STEPS-1];
    logic [MANT_W-1:0]  r_val [0:EXP_STEPS-1];

    logic [SHIFT_W-1:0] w_shift;
    t_tag               r_out_tag;
    logic [AMB_W-1:0]   r_out_amb;

    // scale log2 by 4/5, floor, biased to stay non-negative
    assign w_num = DIVN_W'({i_int, i_frac, 2'b00}) + DIVN_W'(LOG_BIAS);
    assign w_mul = MUL_W'(w_num) * MUL_W'(RECIP5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else begin
            r_a_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mu <= w_mul[RECIP_SHIFT+MU_W-1:RECIP_SHIFT];
    end

    for (genvar gi = 0; gi < EXP_STEPS; gi++) begin : g_step
        localparam logic [MANT_W-1:0] COEF = f_exp2_coef(gi + 1);

        t_tag                w_tag_in;
        logic [MU_W-1:0]     w_mu_in;
        logic [MANT_W-1:0]   w_val_in;
        logic [2*MANT_W-1:0] w_prod;

        if (gi == 0) begin : g_first
            assign w_tag_in = r_a_tag;
            assign w_mu_in  = r_a_mu;
            assign w_val_in = MANT_W'(1) << (MANT_W - 1);
        end else begin : g_next
            assign w_tag_in = r_tag[gi-1];
            assign w_mu_in  = r_mu[gi-1];
            assign w_val_in = r_val[gi-1];
        end

        assign w_prod = (2*MANT_W)'(w_val_in) * (2*MANT_W)'(COEF);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[gi] <= '0;
            end else begin
                r_tag[gi] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_mu[gi]  <= w_mu_in;
            r_val[gi] <= w_mu_in[LOG_FRAC_W-1-gi] ? w_prod[2*MANT_W-2:MANT_W-1] : w_val_in;
        end
    end

    assign w_shift = SHIFT_W'(EXP_SHIFT_BIAS)
                   - SHIFT_W'(r_mu[EXP_STEPS-1][MU_W-1:LOG_FRAC_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_tag <= '0;
        end else begin
            r_out_tag <= r_tag[EXP_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_amb <= r_tag[EXP_STEPS-1].zero ? '0 : AMB_W'(r_val[EXP_STEPS-1] >> w_shift);
    end

    assign o_tag     = r_out_tag;
    assign o_ambient = r_out_amb;

endmodule

// File: rtl/core/blga_scale.sv
`timescale 1ns / 1ps
module blga_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  blga_pkg::t_tag               i_tag,
    input  logic [blga_pkg::AMB_W-1:0]   i_ambient,
    input  logic [blga_pkg::OUT_W-1:0]   i_drive_floor,
    input  logic                         i_invert,
    output logic                         o_strobe,
    output logic [blga_pkg::OUT_W-1:0]   o_drive_level
);
    import blga_pkg::*;

    localparam int GA_W = GAIN_W + AMB_W;

    logic [OUT_W-1:0]  w_span;
    logic [SUM_W-1:0]  w_sum;
    logic [OUT_W-1:0]  w_clamped;

    logic              r_ga_valid;
    logic [GA_W-1:0]   r_ga;
    logic              r_prod_valid;
    logic [PROD_W-1:0] r_prod;
    logic              r_strobe;
    logic [OUT_W-1:0]  r_drive;

    assign w_span    = OUT_MAX - i_drive_floor;
    assign w_sum     = SUM_W'(i_drive_floor) + SUM_W'(r_prod[PROD_W-1:SCALE_SHIFT]);
    assign w_clamped = (w_sum > SUM_W'(OUT_MAX)) ? OUT_MAX : w_sum[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ga_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_ga_valid   <= i_tag.valid;
            r_prod_valid <= r_ga_valid;
            r_strobe     <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ga    <= GA_W'(i_tag.gain) * GA_W'(i_ambient);
        r_prod  <= PROD_W'(r_ga) * PROD_W'(w_span);
        r_drive <= i_invert ? (OUT_MAX - w_clamped) : w_clamped;
    end

    assign o_strobe      = r_strobe;
    assign o_drive_level = r_drive;

endmodule

// File: rtl/core/backlight_level_gamma_ambient.sv
`timescale 1ns / 1ps
// Backlight drive from a brightness level and an ambient lux reading. One request is taken
// in every clock cycle (start while busy is low); busy is high only during reset and the
// first cycle after it. Each result appears on o_drive_level with o_strobe for exactly one
// cycle, after passing an 18-step restoring divider for the lux ratio, a 16-step log2
// squaring chain and a 16-step exp2 product chain. There is no backpressure, so capture
// every result on its strobe. Write configuration only while no request is in flight.
module backlight_level_gamma_ambient (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [blga_pkg::LEVEL_W-1:0]      i_brightness_level,
    input  logic [blga_pkg::LUX_W-1:0]        i_ambient_lux,
    output logic                              o_strobe,
    output logic [blga_pkg::OUT_W-1:0]        o_drive_level,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [blga_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [blga_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import blga_pkg::*;

    logic                 r_busy;
    logic [OUT_W-1:0]     r_drive_floor;
    logic [LUX_W-1:0]     r_lux_factor;
    logic                 r_invert;

    logic                 w_accept;
    logic                 w_cfg_write;
    logic [LEVEL_W-1:0]   w_level_sat;
    logic [LUX_SAT_W-1:0] w_lux_sat;

    t_tag                 r_tag;
    logic [RATIO_W-1:0]   r_num;

    t_tag                 w_div_tag;
    logic [RATIO_W-1:0]   w_ratio;
    t_tag                 w_log_tag;
    logic [EXP_W-1:0]     w_log_int;
    logic [LOG_FRAC_W-1:0] w_log_frac;
    t_tag                 w_exp_tag;
    logic [AMB_W-1:0]     w_ambient;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign w_accept    = start && !r_busy;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_drive_floor <= DRIVE_FLOOR_RST;
            r_lux_factor  <= LUX_FACTOR_RST;
            r_invert      <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (w_cfg_write) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_DRIVE_FLOOR: r_drive_floor <= i_cfg_data[OUT_W-1:0];
                    CFG_LUX_FACTOR:  r_lux_factor  <= i_cfg_data[LUX_W-1:0];
                    CFG_INVERT:      r_invert      <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign w_level_sat = (i_brightness_level > LEVEL_W'(LEVEL_CAP)) ? LEVEL_W'(LEVEL_CAP)
                                                                   : i_brightness_level;
    assign w_lux_sat   = (i_ambient_lux > LUX_W'(LUX_CAP)) ? LUX_SAT_W'(LUX_CAP)
                                                           : i_ambient_lux[LUX_SAT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag.valid <= w_accept;
            r_tag.zero  <= (i_ambient_lux == '0);
            r_tag.gain  <= LEVEL_GAMMA[w_level_sat];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= {w_lux_sat, {RATIO_FRAC{1'b0}}};
    end

    blga_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag),
        .i_num   (r_num),
        .i_den   (r_lux_factor),
        .o_tag   (w_div_tag),
        .o_quot  (w_ratio)
    );

    blga_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_div_tag),
        .i_ratio (w_ratio),
        .o_tag   (w_log_tag),
        .o_int   (w_log_int),
        .o_frac  (w_log_frac)
    );

    blga_exp2 u_exp2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (w_log_tag),
        .i_int     (w_log_int),
        .i_frac    (w_log_frac),
        .o_tag     (w_exp_tag),
        .o_ambient (w_ambient)
    );

    blga_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (w_exp_tag),
        .i_ambient     (w_ambient),
        .i_drive_floor (r_drive_floor),
        .i_invert      (r_invert),
        .o_strobe      (o_strobe),
        .o_drive_level (o_drive_level)
    );

    a_request_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##PIPE_LATENCY o_strobe
    ) else $error("request did not produce a result at the pipeline latency");

    a_result_has_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, PIPE_LATENCY)
    ) else $error("result strobe without a matching request");

    a_floor_kept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !r_invert) |-> (o_drive_level >= r_drive_floor)
    ) else $error("drive level below its floor");

    a_inverted_ceiling: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_invert) |-> (o_drive_level <= (OUT_MAX - r_drive_floor))
    ) else $error("inverted drive level above its ceiling");

endmodule
